// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both expect clk and rst in scope; checks are off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever pre holds, post must hold on the next clock.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/gbfr_pkg.sv
`timescale 1ns / 1ps

package gbfr_pkg;

  // Largest whole frame (header, payload and checksum) the receiver takes.
  localparam int MAX_FRAME_BYTES = 512;

  // Position counter: highest position reached is MAX_FRAME_BYTES - 1.
  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  // Width for length compares: 16-bit length plus carry.
  localparam int CHK_W = 17;

  localparam int HDR_BYTES  = 4;  // class, id, length low, length high
  localparam int OVERHEAD   = 6;  // header plus two checksum bytes

  localparam int IDX_W = 9;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD_SUM  = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic [15:0]      msg_id;
    logic [15:0]      length;
    logic [15:0]      calc_sum;
    logic [15:0]      recv_sum;
  } result_t;

endpackage

// File: design/gbfr_out_queue.sv
`timescale 1ns / 1ps

// Two-entry result queue: output register plus skid entry.
module gbfr_out_queue
  import gbfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    second;
  logic       pop;

  assign pop       = (count != 2'd0) && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (!push && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // payload entries need no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= second;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push && (count == 2'd0)) begin
      head <= push_data;
    end
    if (push && !pop && (count == 2'd1)) begin
      second <= push_data;
    end
  end

endmodule

// File: design/gnss_binary_frame_receiver_top.sv
`timescale 1ns / 1ps

// Binary frame receiver. Takes one received byte per word on the input
// channel and hunts for frames opening with the sync pair B5h 62h, followed
// by class, id, a little-endian 16-bit payload length, the payload and the
// two checksum bytes A then B. Each payload byte leaves as its own result
// word with its index; after the last checksum byte a good or mismatch word
// carries both the computed Fletcher-8 sum (over class, id, length and
// payload) and the received one. A header whose length plus six exceeds
// MAX_FRAME_BYTES gives a length-too-long word and hunting resumes at once.
// A wrong second sync byte drops back to hunting silently. Rate: one byte
// per clock while in_stall is low; the parser does all its work for a byte
// in the cycle it is taken, and its result word is registered in the output
// queue. Results go through a two-word queue (output register plus skid
// entry), so in_stall rises only when both hold words the sink has not
// taken. No memory, no clearing pass after reset.
`include "assert_macros.svh"

module gnss_binary_frame_receiver_top
  import gbfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [8:0]  payload_index,
  output logic [15:0] msg_id,
  output logic [15:0] payload_length,
  output logic [15:0] computed_checksum,
  output logic [15:0] received_checksum
);

  // sync_phase codes
  localparam logic [1:0] PH_HUNT  = 2'd0;  // waiting for first sync byte
  localparam logic [1:0] PH_SYNC2 = 2'd1;  // expecting second sync byte
  localparam logic [1:0] PH_FRAME = 2'd2;  // inside a frame

  // header byte positions
  localparam logic [1:0] HDR_CLASS  = 2'd0;
  localparam logic [1:0] HDR_ID     = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_LEN_HI = 2'd3;

  // parser state
  logic [1:0]       sync_phase, sync_phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      frame_length, frame_length_next;
  logic [15:0]      frame_id, frame_id_next;
  logic [7:0]       sum_a, sum_a_next;
  logic [7:0]       sum_b, sum_b_next;
  logic [7:0]       tail_first, tail_first_next;

  logic             in_acc;
  logic             res_push;
  result_t          res;
  result_t          head;
  logic             q_full;

  // Fletcher-8 step over the incoming byte
  logic [7:0]       add_a, add_b;
  logic [CHK_W-1:0] pos_ext, payload_end, new_frame_bytes, pos_m4;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  assign add_a       = sum_a + rx_byte;
  assign add_b       = sum_b + add_a;
  assign pos_ext     = CHK_W'(byte_position);
  assign payload_end = {1'b0, frame_length} + CHK_W'(HDR_BYTES);
  assign pos_m4      = pos_ext - CHK_W'(HDR_BYTES);
  // length high byte arrives with the current byte
  assign new_frame_bytes = {1'b0, rx_byte, frame_length[7:0]} + CHK_W'(OVERHEAD);

  always_comb begin
    sync_phase_next    = sync_phase;
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    frame_id_next      = frame_id;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    tail_first_next    = tail_first;
    res_push           = 1'b0;
    res                = '0;

    case (sync_phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_FIRST) begin
          sync_phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          sync_phase_next    = PH_FRAME;
          byte_position_next = '0;
          frame_length_next  = '0;
          frame_id_next      = '0;
          sum_a_next         = '0;
          sum_b_next         = '0;
          tail_first_next    = '0;
        end else begin
          sync_phase_next = PH_HUNT;
        end
      end
      PH_FRAME: begin
        byte_position_next = byte_position + POS_W'(1);
        if (pos_ext < CHK_W'(HDR_BYTES)) begin
          sum_a_next = add_a;
          sum_b_next = add_b;
          case (byte_position[1:0])
            HDR_CLASS:  frame_id_next = {rx_byte, frame_id[7:0]};
            HDR_ID:     frame_id_next = {frame_id[15:8], rx_byte};
            HDR_LEN_LO: frame_length_next = {frame_length[15:8], rx_byte};
            HDR_LEN_HI: begin
              frame_length_next = {rx_byte, frame_length[7:0]};
              if (new_frame_bytes > CHK_W'(MAX_FRAME_BYTES)) begin
                sync_phase_next = PH_HUNT;
                res_push        = 1'b1;
                res.kind        = KIND_TOO_LONG;
              end
            end
            default: ;
          endcase
        end else if (pos_ext < payload_end) begin
          sum_a_next = add_a;
          sum_b_next = add_b;
          res_push   = 1'b1;
          res.kind   = KIND_PAYLOAD;
          res.data   = rx_byte;
          res.index  = pos_m4[IDX_W-1:0];
        end else if (pos_ext == payload_end) begin
          tail_first_next = rx_byte;
        end else begin
          // second checksum byte closes the frame
          sync_phase_next    = PH_HUNT;
          byte_position_next = '0;
          res_push           = 1'b1;
          res.calc_sum       = {sum_a, sum_b};
          res.recv_sum       = {tail_first, rx_byte};
          res.kind = ({sum_a, sum_b} == {tail_first, rx_byte}) ? KIND_GOOD : KIND_BAD_SUM;
        end
      end
      default: sync_phase_next = PH_HUNT;
    endcase

    res.msg_id = frame_id_next;
    res.length = frame_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_phase    <= PH_HUNT;
      byte_position <= '0;
      frame_length  <= '0;
      frame_id      <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
      tail_first    <= '0;
    end else if (in_acc) begin
      sync_phase    <= sync_phase_next;
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      frame_id      <= frame_id_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
      tail_first    <= tail_first_next;
    end
  end

  gbfr_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc && res_push),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind       = head.kind;
  assign data_byte         = head.data;
  assign payload_index     = head.index;
  assign msg_id            = head.msg_id;
  assign payload_length    = head.length;
  assign computed_checksum = head.calc_sum;
  assign received_checksum = head.recv_sum;

  // A stalled input means both queue words are occupied.
  `ASSERT_ALWAYS(a_stall_has_word, !in_stall || out_valid, "input stalled with empty queue")

  // Payload words only index inside the declared payload.
  `ASSERT_ALWAYS(a_payload_in_range, !(in_acc && res_push && (res.kind == KIND_PAYLOAD)) || (CHK_W'(res.index) < {1'b0, frame_length}), "payload index beyond length")

  // A frame verdict always returns the parser to hunting.
  `ASSERT_NEXT(a_verdict_hunts, in_acc && res_push && ((res.kind == KIND_GOOD) || (res.kind == KIND_BAD_SUM)), (sync_phase == PH_HUNT) && (byte_position == '0), "no return to hunt after frame")

  // Position never runs past the largest frame.
  `ASSERT_ALWAYS(a_pos_bound, (sync_phase != PH_FRAME) || (CHK_W'(byte_position) < CHK_W'(MAX_FRAME_BYTES)), "byte position beyond frame limit")

endmodule

// File: tb/gnss_binary_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module gnss_binary_frame_receiver_top_tb;
  import gbfr_pkg::*;

  // Parser phase as the frame model sees it
  typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_FRAME} hunt_e;

  // One row of the directed table. When typed is set, the row's own expectation
  // (has_res and res) stands in place of the predicted one.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       has_res;
    result_t    res;
  } stim_row_t;

  localparam int N_ROWS = 26;
  localparam int RANDOM_BYTES = 1000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [8:0]  payload_index;
  logic [15:0] msg_id;
  logic [15:0] payload_length;
  logic [15:0] computed_checksum;
  logic [15:0] received_checksum;

  // Frame model state, mirrors the parser registers
  hunt_e       hunt = SEEK_FIRST;
  int          frame_pos = 0;
  logic [15:0] hdr_len = '0;
  logic [15:0] hdr_id = '0;
  logic [7:0]  fl_a = '0;
  logic [7:0]  fl_b = '0;
  logic [7:0]  tail_a = '0;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_mode_left = 0;
  stim_row_t   stim_rows [N_ROWS];

  gnss_binary_frame_receiver_top dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_kind       (result_kind),
    .data_byte         (data_byte),
    .payload_index     (payload_index),
    .msg_id            (msg_id),
    .payload_length    (payload_length),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("gnss_binary_frame_receiver_top_tb: FAIL");
    $finish;
  end

  // Frame model: takes one received byte, returns 1 with the result word when
  // the byte gives one.
  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
    int pos;
    res = '0;
    if (hunt == SEEK_FIRST) begin
      if (b == SYNC_FIRST) hunt = SEEK_SECOND;
      return 1'b0;
    end
    if (hunt == SEEK_SECOND) begin
      // anything but the second sync byte (a repeated B5h too) drops to hunting
      if (b == SYNC_SECOND) begin
        hunt = IN_FRAME;
        frame_pos = 0;
        hdr_len = '0;
        hdr_id = '0;
        fl_a = '0;
        fl_b = '0;
        tail_a = '0;
      end else begin
        hunt = SEEK_FIRST;
      end
      return 1'b0;
    end

    pos = frame_pos;
    frame_pos++;
    // Fletcher-8 over class, id, length and payload; hdr_len is still partial
    // in the header but the compare holds there whatever its value
    if (pos < HDR_BYTES + hdr_len) begin
      fl_a = fl_a + b;
      fl_b = fl_b + fl_a;
    end

    if (pos < HDR_BYTES) begin
      case (pos)
        0: hdr_id[15:8] = b;
        1: hdr_id[7:0] = b;
        2: hdr_len[7:0] = b;
        default: begin
          hdr_len[15:8] = b;
          if (hdr_len + OVERHEAD > MAX_FRAME_BYTES) begin
            hunt = SEEK_FIRST;
            res.kind = KIND_TOO_LONG;
            res.msg_id = hdr_id;
            res.length = hdr_len;
            return 1'b1;
          end
        end
      endcase
      return 1'b0;
    end

    res.msg_id = hdr_id;
    res.length = hdr_len;
    if (pos < HDR_BYTES + hdr_len) begin
      res.kind = KIND_PAYLOAD;
      res.data = b;
      res.index = IDX_W'(pos - HDR_BYTES);
      return 1'b1;
    end
    if (pos == HDR_BYTES + hdr_len) begin
      tail_a = b;
      return 1'b0;
    end
    // second tail byte closes the frame, empty payload included
    hunt = SEEK_FIRST;
    frame_pos = 0;
    res.calc_sum = {fl_a, fl_b};
    res.recv_sum = {tail_a, b};
    res.kind = (res.calc_sum == res.recv_sum) ? KIND_GOOD : KIND_BAD_SUM;
    return 1'b1;
  endfunction

  // Offer one byte; the sender idles in bursts. in_valid gets a single
  // nonblocking assignment per time step.
  task automatic send_word(input logic [7:0] b, input bit typed, input bit typed_has,
                           input result_t typed_res);
    int      gap;
    bit      has;
    result_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    has = parse_rx_byte(b, pred);
    if (typed) begin
      has = typed_has;
      pred = typed_res;
    end
    if (has) pending_results.push_back(pred);
  endtask

  // Hold the sender off until every outstanding result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver stall pattern: free running, heavy, light or periodic, switching
  // to a randomly chosen mode whenever the current mode's countdown runs out
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(16, 128);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_mode_left[2];
    endcase
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, kind %0d expected none",
                 $time, result_kind);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_kind", want.kind, result_kind);
        compare_field("data_byte", want.data, data_byte);
        compare_field("payload_index", want.index, payload_index);
        compare_field("msg_id", want.msg_id, msg_id);
        compare_field("payload_length", want.length, payload_length);
        compare_field("computed_checksum", want.calc_sum, computed_checksum);
        compare_field("received_checksum", want.recv_sum, received_checksum);
      end
    end
  end

  initial begin
    logic [7:0]  byte_buf [$];
    logic [7:0]  cls;
    logic [7:0]  idb;
    logic [7:0]  junk;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [15:0] len;
    logic [15:0] tail;
    int          bytes_sent;
    int          frame_no;
    int          long_frames;
    int          pick;
    int          k;
    int          wait_cycles;

    // Directed table.
    // Second sync byte wrong (B5h repeated), then a stray 62h while hunting
    stim_rows[0]  = '{8'hB5, 1'b1, 1'b0, '0};
    stim_rows[1]  = '{8'hB5, 1'b1, 1'b0, '0};
    stim_rows[2]  = '{8'h62, 1'b1, 1'b0, '0};
    // Largest length field: too long, reported at the high length byte
    stim_rows[3]  = '{8'hB5, 1'b1, 1'b0, '0};
    stim_rows[4]  = '{8'h62, 1'b1, 1'b0, '0};
    stim_rows[5]  = '{8'h10, 1'b1, 1'b0, '0};
    stim_rows[6]  = '{8'h20, 1'b1, 1'b0, '0};
    stim_rows[7]  = '{8'hFF, 1'b1, 1'b0, '0};
    stim_rows[8]  = '{8'hFF, 1'b1, 1'b1,
                      '{KIND_TOO_LONG, 8'h00, 9'd0, 16'h1020, 16'hFFFF, 16'h0000, 16'h0000}};
    // Empty payload, sum over the header alone: A=03h B=0Ah
    stim_rows[9]  = '{8'hB5, 1'b0, 1'b0, '0};
    stim_rows[10] = '{8'h62, 1'b0, 1'b0, '0};
    stim_rows[11] = '{8'h01, 1'b0, 1'b0, '0};
    stim_rows[12] = '{8'h02, 1'b0, 1'b0, '0};
    stim_rows[13] = '{8'h00, 1'b0, 1'b0, '0};
    stim_rows[14] = '{8'h00, 1'b0, 1'b0, '0};
    stim_rows[15] = '{8'h03, 1'b0, 1'b0, '0};
    stim_rows[16] = '{8'h0A, 1'b1, 1'b1,
                      '{KIND_GOOD, 8'h00, 9'd0, 16'h0102, 16'h0000, 16'h030A, 16'h030A}};
    // One payload byte, then a wrong checksum
    stim_rows[17] = '{8'hB5, 1'b0, 1'b0, '0};
    stim_rows[18] = '{8'h62, 1'b0, 1'b0, '0};
    stim_rows[19] = '{8'hFF, 1'b0, 1'b0, '0};
    stim_rows[20] = '{8'h00, 1'b0, 1'b0, '0};
    stim_rows[21] = '{8'h01, 1'b0, 1'b0, '0};
    stim_rows[22] = '{8'h00, 1'b0, 1'b0, '0};
    stim_rows[23] = '{8'h80, 1'b1, 1'b1,
                      '{KIND_PAYLOAD, 8'h80, 9'd0, 16'hFF00, 16'h0001, 16'h0000, 16'h0000}};
    stim_rows[24] = '{8'h00, 1'b0, 1'b0, '0};
    stim_rows[25] = '{8'h00, 1'b0, 1'b0, '0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_ROWS; k++)
      send_word(stim_rows[k].rx, stim_rows[k].typed, stim_rows[k].has_res, stim_rows[k].res);
    drain_results();

    // Random part: mostly well-formed frames with random content, the rest
    // oversize headers, broken sync, cut-short frames and line noise
    bytes_sent = 0;
    frame_no = 0;
    long_frames = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 19);
      if (frame_no == 4) pick = 13;  // make sure one full-size frame goes through
      if (pick == 13 && long_frames >= 2) pick = 0;
      cls = $urandom;
      idb = $urandom;
      case (pick)
        13: begin
          len = (long_frames == 0) ? 16'd506 : 16'($urandom_range(256, 506));
          long_frames++;
        end
        14: begin
          case ($urandom_range(0, 3))
            0: len = 16'(MAX_FRAME_BYTES - OVERHEAD + 1);  // one past the limit
            1: len = 16'hFFFF;
            default: len = 16'($urandom_range(MAX_FRAME_BYTES - OVERHEAD + 1, 65535));
          endcase
        end
        default: len = 16'($urandom_range(0, 16));
      endcase

      if (pick <= 14) begin
        byte_buf = {SYNC_FIRST, SYNC_SECOND, cls, idb, len[7:0], len[15:8]};
        if (len + OVERHEAD <= MAX_FRAME_BYTES) begin
          for (k = 0; k < len; k++) byte_buf.push_back(8'($urandom));
          sa = '0;
          sb = '0;
          for (k = 2; k < byte_buf.size(); k++) begin
            sa = sa + byte_buf[k];
            sb = sb + sa;
          end
          tail = {sa, sb};
          if ($urandom_range(0, 5) == 0) tail = tail ^ 16'(1 << $urandom_range(0, 15));
          byte_buf.push_back(tail[15:8]);
          byte_buf.push_back(tail[7:0]);
        end
      end else if (pick == 15) begin
        junk = $urandom;
        if (junk == SYNC_SECOND) junk = SYNC_FIRST;
        byte_buf = {SYNC_FIRST, junk};
      end else if (pick == 16) begin
        // frame cut short: whatever follows is parsed as its continuation
        byte_buf = {SYNC_FIRST, SYNC_SECOND};
        repeat ($urandom_range(0, 3)) byte_buf.push_back(8'($urandom));
      end else begin
        byte_buf.delete();
        repeat ($urandom_range(1, 6)) byte_buf.push_back(8'($urandom));
      end

      for (k = 0; k < byte_buf.size(); k++)
        send_word(byte_buf[k], 1'b0, 1'b0, '0);
      bytes_sent += byte_buf.size();
      frame_no++;
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    // Wind down: let the last words out, bounded
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time,
               pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("gnss_binary_frame_receiver_top_tb: PASS");
    end else begin
      $display("gnss_binary_frame_receiver_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/gbfr_pkg.sv
design/gbfr_out_queue.sv
design/gnss_binary_frame_receiver_top.sv
tb/gnss_binary_frame_receiver_top_tb.sv
